### rtl/dtps_pkg.sv
// Shared types, codes, defaults and palette helpers for the depth-tested pixel store.
`default_nettype none
package dtps_pkg;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_DEPTH_BITS = 32;

    // Field and register widths fixed by the interface
    localparam int MODE_W    = 3;
    localparam int COL_W     = 8;
    localparam int ROW_W     = 7;
    localparam int COLOUR_W  = 24;
    localparam int ZIN_W     = 32;
    localparam int WIDTH_W   = 9;
    localparam int HEIGHT_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 9;
    localparam int PAL_W     = 8;
    // Linear pixel index and pixel count: widest width register times widest height
    localparam int CNT_W     = WIDTH_W + HEIGHT_W;

    // Reset values of the frame size registers
    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = WIDTH_W'(256);
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = HEIGHT_W'(128);

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_PLOT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DPLOT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FILL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // Palette index of colour zero
    localparam logic [PAL_W-1:0] PALETTE_BASE = 8'd16;

    typedef struct packed {
        logic [MODE_W-1:0]          mode;
        logic [COL_W-1:0]           column;
        logic [ROW_W-1:0]           row;
        logic [COLOUR_W-1:0]        colour_word;
        logic signed [ZIN_W-1:0]    depth_value;
    } t_in_word;

    typedef struct packed {
        logic [COLOUR_W-1:0] pixel_value;
        logic [PAL_W-1:0]    palette_index;
        logic                in_bounds;
        logic                was_written;
    } t_out_word;

    // Write strobes from the control path to the stores
    typedef struct packed {
        logic frame_we;
        logic depth_we;
    } t_store_ctl;

    // Cube level of one channel: 0 below 4, else (c - 4) / 42
    function automatic logic [2:0] pal_level(input logic [7:0] c);
        logic [2:0] lv;
        lv = 3'd0;
        if (c >= 8'd46)  lv = 3'd1;
        if (c >= 8'd88)  lv = 3'd2;
        if (c >= 8'd130) lv = 3'd3;
        if (c >= 8'd172) lv = 3'd4;
        if (c >= 8'd214) lv = 3'd5;
        return lv;
    endfunction

    // 16 + b' + 6 g' + 36 r' for a colour packed blue, green, red
    function automatic logic [PAL_W-1:0] palette_of(input logic [COLOUR_W-1:0] colour);
        logic [PAL_W-1:0] r_lv;
        logic [PAL_W-1:0] g_lv;
        logic [PAL_W-1:0] b_lv;
        r_lv = PAL_W'(pal_level(colour[7:0]));
        g_lv = PAL_W'(pal_level(colour[15:8]));
        b_lv = PAL_W'(pal_level(colour[23:16]));
        return PALETTE_BASE + b_lv + (g_lv << 2) + (g_lv << 1)
               + (r_lv << 5) + (r_lv << 2);
    endfunction

endpackage
`default_nettype wire

### rtl/dtps_store.sv
// Colour and depth memories, one write and one registered read port each.
`default_nettype none
module dtps_store #(
    parameter int ENTRIES    = dtps_pkg::DEF_MAX_WIDTH * dtps_pkg::DEF_MAX_HEIGHT,
    parameter int ADDR_W     = $clog2(ENTRIES),
    parameter int DEPTH_BITS = dtps_pkg::DEF_DEPTH_BITS
) (
    input  wire logic                              i_clk,
    input  wire dtps_pkg::t_store_ctl              i_ctl,
    input  wire logic [ADDR_W-1:0]                 i_wr_addr,
    input  wire logic [dtps_pkg::COLOUR_W-1:0]     i_wr_colour,
    input  wire logic [DEPTH_BITS-1:0]             i_wr_depth,
    input  wire logic [ADDR_W-1:0]                 i_rd_addr,
    output      logic [dtps_pkg::COLOUR_W-1:0]     o_rd_colour,
    output      logic [DEPTH_BITS-1:0]             o_rd_depth
);

    logic [dtps_pkg::COLOUR_W-1:0] r_frame_mem [ENTRIES];
    logic [DEPTH_BITS-1:0]         r_depth_mem [ENTRIES];

    // Write colour, read registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.frame_we) begin
            r_frame_mem[i_wr_addr] <= i_wr_colour;
        end
        o_rd_colour <= r_frame_mem[i_rd_addr];
    end

    // Write depth, read registered
    always_ff @(posedge i_clk) begin
        if (i_ctl.depth_we) begin
            r_depth_mem[i_wr_addr] <= i_wr_depth;
        end
        o_rd_depth <= r_depth_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### rtl/dtps_core.sv
// Control path: frame size registers, address calculation, sequencer and result register.
`default_nettype none
module dtps_core #(
    parameter int MAX_WIDTH  = dtps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtps_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = dtps_pkg::DEF_DEPTH_BITS,
    parameter int ADDR_W     = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dtps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dtps_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire dtps_pkg::t_in_word                 i_in_word,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      dtps_pkg::t_out_word                o_out_word,
    output      dtps_pkg::t_store_ctl               o_ctl,
    output      logic [ADDR_W-1:0]                  o_wr_addr,
    output      logic [dtps_pkg::COLOUR_W-1:0]      o_wr_colour,
    output      logic [DEPTH_BITS-1:0]              o_wr_depth,
    output      logic [ADDR_W-1:0]                  o_rd_addr,
    input  wire logic [dtps_pkg::COLOUR_W-1:0]      i_rd_colour,
    input  wire logic [DEPTH_BITS-1:0]              i_rd_depth
);

    localparam int W_MAXV = (1 << dtps_pkg::WIDTH_W) - 1;
    localparam int H_MAXV = (1 << dtps_pkg::HEIGHT_W) - 1;
    localparam int W_CAP  = (MAX_WIDTH > W_MAXV) ? W_MAXV : MAX_WIDTH;
    localparam int H_CAP  = (MAX_HEIGHT > H_MAXV) ? H_MAXV : MAX_HEIGHT;
    localparam int CNT_W  = dtps_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]                         r_state, n_state;
    logic [dtps_pkg::WIDTH_W-1:0]       r_width;
    logic [dtps_pkg::HEIGHT_W-1:0]      r_height;
    logic [dtps_pkg::MODE_W-1:0]        r_mode, n_mode;
    logic                               r_inside, n_inside;
    logic [ADDR_W-1:0]                  r_addr, n_addr;
    logic [dtps_pkg::COLOUR_W-1:0]      r_colour, n_colour;
    logic signed [DEPTH_BITS-1:0]       r_depth, n_depth;
    logic [CNT_W-1:0]                   r_cnt, n_cnt;
    logic [CNT_W-1:0]                   r_total, n_total;
    logic                               r_out_valid, n_out_valid;
    dtps_pkg::t_out_word                r_out_word, n_out_word;

    logic [dtps_pkg::WIDTH_W-1:0]       w_eff;
    logic [dtps_pkg::HEIGHT_W-1:0]      h_eff;
    logic                               in_fire;
    logic                               in_inside;
    logic [CNT_W-1:0]                   in_index;
    logic [ADDR_W-1:0]                  in_addr;
    logic [CNT_W-1:0]                   area;
    logic signed [DEPTH_BITS-1:0]       in_depth;
    logic                               out_free;
    logic                               is_sweep_mode;
    logic                               depth_pass;
    logic                               rd_hit;

    // Saturate the frame size to the store dimensions
    assign w_eff = (r_width > dtps_pkg::WIDTH_W'(W_CAP)) ? dtps_pkg::WIDTH_W'(W_CAP) : r_width;
    assign h_eff = (r_height > dtps_pkg::HEIGHT_W'(H_CAP)) ?
                   dtps_pkg::HEIGHT_W'(H_CAP) : r_height;

    // Bounds check and linear index width * row + column
    assign in_inside = (dtps_pkg::WIDTH_W'(i_in_word.column) < w_eff) &&
                       (dtps_pkg::HEIGHT_W'(i_in_word.row) < h_eff);
    assign in_index  = CNT_W'(w_eff) * CNT_W'(i_in_word.row) + CNT_W'(i_in_word.column);
    assign in_addr   = ADDR_W'(32'(in_index));
    assign area      = CNT_W'(w_eff) * CNT_W'(h_eff);

    // Sign-extend and saturate the incoming depth to the stored width
    generate
        if (DEPTH_BITS >= dtps_pkg::ZIN_W) begin : g_depth_ext
            assign in_depth = DEPTH_BITS'(i_in_word.depth_value);
        end else begin : g_depth_sat
            logic [dtps_pkg::ZIN_W-DEPTH_BITS:0] top_bits;
            assign top_bits = i_in_word.depth_value[dtps_pkg::ZIN_W-1:DEPTH_BITS-1];
            assign in_depth = ((&top_bits) || !(|top_bits)) ?
                              i_in_word.depth_value[DEPTH_BITS-1:0] :
                              (i_in_word.depth_value[dtps_pkg::ZIN_W-1] ?
                               {1'b1, {(DEPTH_BITS-1){1'b0}}} :
                               {1'b0, {(DEPTH_BITS-1){1'b1}}});
        end
    endgenerate

    assign o_in_ready    = (r_state == ST_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;
    assign is_sweep_mode = (i_in_word.mode == dtps_pkg::MODE_FILL) ||
                           (i_in_word.mode == dtps_pkg::MODE_CLEAR);
    assign depth_pass    = (r_depth >= signed'(i_rd_depth));
    assign rd_hit        = (r_mode == dtps_pkg::MODE_READ) && r_inside;

    // Hold the read address while an item is in flight
    assign o_rd_addr   = (r_state == ST_IDLE) ? in_addr : r_addr;
    assign o_wr_colour = r_colour;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_inside    = r_inside;
        n_addr      = r_addr;
        n_colour    = r_colour;
        n_depth     = r_depth;
        n_cnt       = r_cnt;
        n_total     = r_total;
        n_out_valid = r_out_valid;
        n_out_word  = r_out_word;
        o_ctl       = '0;
        o_wr_addr   = r_addr;
        o_wr_depth  = r_depth;

        // Drop the result word once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_mode   = i_in_word.mode;
                    n_inside = in_inside;
                    n_addr   = in_addr;
                    n_colour = i_in_word.colour_word;
                    n_depth  = in_depth;
                    n_cnt    = '0;
                    n_total  = area;
                    if (is_sweep_mode && (area != '0)) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_SWEEP: begin
                // Write one entry a cycle across the active frame
                o_ctl.frame_we = (r_mode == dtps_pkg::MODE_FILL);
                o_ctl.depth_we = (r_mode == dtps_pkg::MODE_CLEAR);
                o_wr_addr      = ADDR_W'(32'(r_cnt));
                o_wr_depth     = '0;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == r_total - CNT_W'(1)) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Finish the item once the result register is free
                if (out_free) begin
                    n_out_word.pixel_value   = rd_hit ? i_rd_colour : '0;
                    n_out_word.palette_index = rd_hit ? dtps_pkg::palette_of(i_rd_colour) :
                                               dtps_pkg::PALETTE_BASE;
                    n_out_word.in_bounds     = r_inside &&
                                               ((r_mode == dtps_pkg::MODE_PLOT) ||
                                                (r_mode == dtps_pkg::MODE_DPLOT) ||
                                                (r_mode == dtps_pkg::MODE_READ));
                    n_out_word.was_written   = 1'b0;
                    if ((r_mode == dtps_pkg::MODE_PLOT) && r_inside) begin
                        o_ctl.frame_we         = 1'b1;
                        n_out_word.was_written = 1'b1;
                    end
                    if ((r_mode == dtps_pkg::MODE_DPLOT) && r_inside && depth_pass) begin
                        o_ctl.frame_we         = 1'b1;
                        o_ctl.depth_we         = 1'b1;
                        n_out_word.was_written = 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_width     <= dtps_pkg::RST_WIDTH;
            r_height    <= dtps_pkg::RST_HEIGHT;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    dtps_pkg::CFG_FRAME_WIDTH: begin
                        r_width <= i_cfg_data[dtps_pkg::WIDTH_W-1:0];
                    end
                    dtps_pkg::CFG_FRAME_HEIGHT: begin
                        r_height <= i_cfg_data[dtps_pkg::HEIGHT_W-1:0];
                    end
                    default: begin
                        r_width <= r_width;
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_inside   <= n_inside;
        r_addr     <= n_addr;
        r_colour   <= n_colour;
        r_depth    <= n_depth;
        r_cnt      <= n_cnt;
        r_total    <= n_total;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

### rtl/depth_tested_pixel_store.sv
// Top level of the depth-tested pixel store: control path and colour/depth memories.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per item:
//   plot, depth-tested plot, read, fill or clear depth. Every item returns one
//   word on the output channel (o_out_valid / i_out_ready / o_out_word).
//   Frame width and height are written on the config port (i_cfg_we, index,
//   data) by the user only while the block is idle; the block does not enforce it.
// Sequencing:
//   Plot, depth-tested plot and read go through the registered memory read,
//   then compare, write-back and result. The next word is taken as soon as
//   the previous one has moved to the result register.
//   Fill and clear depth sweep the active frame one entry a cycle, a rate set
//   by the single write port of each memory.
// Reset:
//   Synchronous, active low. Clears the sequencer and the result valid flag and
//   loads width 256 and height 128. Memory contents are undefined until written.
// Stalls:
//   A finished word waits in the result register while i_out_ready is low; one
//   more item is accepted and parks until that register frees up.
`default_nettype none
module depth_tested_pixel_store #(
    parameter int MAX_WIDTH  = dtps_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dtps_pkg::DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = dtps_pkg::DEF_DEPTH_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [dtps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [dtps_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire dtps_pkg::t_in_word                 i_in_word,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      dtps_pkg::t_out_word                o_out_word
);

    localparam int ENTRIES = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(ENTRIES);

    dtps_pkg::t_store_ctl            store_ctl;
    logic [ADDR_W-1:0]               wr_addr;
    logic [ADDR_W-1:0]               rd_addr;
    logic [dtps_pkg::COLOUR_W-1:0]   wr_colour;
    logic [dtps_pkg::COLOUR_W-1:0]   rd_colour;
    logic [DEPTH_BITS-1:0]           wr_depth;
    logic [DEPTH_BITS-1:0]           rd_depth;

    dtps_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .DEPTH_BITS (DEPTH_BITS),
        .ADDR_W     (ADDR_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_ctl       (store_ctl),
        .o_wr_addr   (wr_addr),
        .o_wr_colour (wr_colour),
        .o_wr_depth  (wr_depth),
        .o_rd_addr   (rd_addr),
        .i_rd_colour (rd_colour),
        .i_rd_depth  (rd_depth)
    );

    dtps_store #(
        .ENTRIES    (ENTRIES),
        .ADDR_W     (ADDR_W),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (store_ctl),
        .i_wr_addr   (wr_addr),
        .i_wr_colour (wr_colour),
        .i_wr_depth  (wr_depth),
        .i_rd_addr   (rd_addr),
        .o_rd_colour (rd_colour),
        .o_rd_depth  (rd_depth)
    );

endmodule
`default_nettype wire

### rtl/dtps_checker.sv
// Port-level checks for the depth-tested pixel store, bound to the top level.
`default_nettype none
module dtps_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire dtps_pkg::t_out_word            o_out_word
);

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))
        else $error("result word changed while stalled");

    // Come out of reset with no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // Keep the palette index inside the color cube
    a_pal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.palette_index >= 8'd16 &&
                         o_out_word.palette_index <= 8'd231))
        else $error("palette index out of range");

    // Zero pixel and base palette on an out-of-bounds word
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.in_bounds) |->
        (o_out_word.pixel_value == '0 &&
         o_out_word.palette_index == dtps_pkg::PALETTE_BASE &&
         !o_out_word.was_written))
        else $error("out-of-bounds word carries data");

    // Accept no new word the cycle after one was taken
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken back to back");

endmodule

bind depth_tested_pixel_store dtps_checker u_dtps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
`default_nettype wire

### sim/tb_depth_tested_pixel_store.sv
// Testbench for the depth-tested pixel store: directed and random words checked against a shadow model.
`timescale 1ns / 100ps
`default_nettype none
module tb_depth_tested_pixel_store;

    localparam int STORE_SIZE    = dtps_pkg::DEF_MAX_WIDTH * dtps_pkg::DEF_MAX_HEIGHT;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int ITEM_TARGET   = 1100;
    localparam int REPORT_LIMIT  = 10;
    // Largest active area for which random fill and clear are issued
    localparam int SWEEP_AREA    = 2048;
    // Channel level: 0 below LEVEL_FLOOR, else (c - LEVEL_FLOOR) / LEVEL_STEP
    localparam int LEVEL_FLOOR   = 4;
    localparam int LEVEL_STEP    = 42;
    // First of the spare mode codes, which the block ignores
    localparam logic [dtps_pkg::MODE_W-1:0] MODE_SPARE = dtps_pkg::MODE_CLEAR + 3'd1;
    localparam logic [dtps_pkg::ZIN_W-1:0] DEPTH_MIN = 32'h8000_0000;
    localparam logic [dtps_pkg::ZIN_W-1:0] DEPTH_MAX = 32'h7FFF_FFFF;

    // Shadow of the color and depth memories plus the queue of predicted result words
    class pixel_store_scoreboard;
        bit [dtps_pkg::COLOUR_W-1:0]     colour_shadow [STORE_SIZE];
        bit signed [dtps_pkg::ZIN_W-1:0] depth_shadow [STORE_SIZE];
        int unsigned                     width_reg;
        int unsigned                     height_reg;
        dtps_pkg::t_out_word             predicted_words [$];
        int                              mismatches;

        function new();
            width_reg  = 32'(dtps_pkg::RST_WIDTH);
            height_reg = 32'(dtps_pkg::RST_HEIGHT);
            mismatches = 0;
        endfunction

        function void set_reg(logic [dtps_pkg::CFG_IDX_W-1:0] idx,
                              logic [dtps_pkg::CFG_DAT_W-1:0] data);
            if (idx == dtps_pkg::CFG_FRAME_WIDTH) begin
                width_reg = 32'(data[dtps_pkg::WIDTH_W-1:0]);
            end else begin
                height_reg = 32'(data[dtps_pkg::HEIGHT_W-1:0]);
            end
        endfunction

        function int unsigned cube_level(bit [7:0] c);
            return (c < LEVEL_FLOOR) ? 0 : (c - LEVEL_FLOOR) / LEVEL_STEP;
        endfunction

        function int pending();
            return predicted_words.size();
        endfunction

        // Apply one accepted word to the shadow and queue the result it must give
        function void note_word(dtps_pkg::t_in_word word);
            int unsigned         w;
            int unsigned         h;
            int unsigned         idx;
            int unsigned         area;
            int unsigned         i;
            bit                  in_frame;
            dtps_pkg::t_out_word res;
            w        = (width_reg > dtps_pkg::DEF_MAX_WIDTH) ? dtps_pkg::DEF_MAX_WIDTH : width_reg;
            h        = (height_reg > dtps_pkg::DEF_MAX_HEIGHT) ?
                       dtps_pkg::DEF_MAX_HEIGHT : height_reg;
            area     = w * h;
            in_frame = (word.column < w) && (word.row < h);
            idx      = in_frame ? w * word.row + word.column : 0;
            res.pixel_value   = '0;
            res.palette_index = dtps_pkg::PALETTE_BASE;
            res.in_bounds     = 1'b0;
            res.was_written   = 1'b0;
            case (word.mode)
                dtps_pkg::MODE_PLOT: begin
                    res.in_bounds = in_frame;
                    if (in_frame) begin
                        colour_shadow[idx] = word.colour_word;
                        res.was_written    = 1'b1;
                    end
                end
                dtps_pkg::MODE_DPLOT: begin
                    res.in_bounds = in_frame;
                    if (in_frame && $signed(word.depth_value) >= depth_shadow[idx]) begin
                        depth_shadow[idx]  = word.depth_value;
                        colour_shadow[idx] = word.colour_word;
                        res.was_written    = 1'b1;
                    end
                end
                dtps_pkg::MODE_READ: begin
                    res.in_bounds = in_frame;
                    if (in_frame) begin
                        res.pixel_value   = colour_shadow[idx];
                        res.palette_index = dtps_pkg::PAL_W'(dtps_pkg::PALETTE_BASE
                            + cube_level(colour_shadow[idx][23:16])
                            + 6 * cube_level(colour_shadow[idx][15:8])
                            + 36 * cube_level(colour_shadow[idx][7:0]));
                    end
                end
                dtps_pkg::MODE_FILL: begin
                    for (i = 0; i < area; i++) colour_shadow[i] = word.colour_word;
                end
                dtps_pkg::MODE_CLEAR: begin
                    for (i = 0; i < area; i++) depth_shadow[i] = '0;
                end
                default: ;
            endcase
            predicted_words.push_back(res);
        endfunction

        // Compare one delivered word with the oldest prediction
        function void check_word(dtps_pkg::t_out_word got);
            dtps_pkg::t_out_word exp_word;
            if (predicted_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result word: pixel %06h pal %0d inb %0b wr %0b",
                             got.pixel_value, got.palette_index, got.in_bounds,
                             got.was_written);
                return;
            end
            exp_word = predicted_words.pop_front();
            if (got.pixel_value !== exp_word.pixel_value
                    || got.palette_index !== exp_word.palette_index
                    || got.in_bounds !== exp_word.in_bounds
                    || got.was_written !== exp_word.was_written) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected pixel %06h pal %0d inb %0b wr %0b, %s",
                             exp_word.pixel_value, exp_word.palette_index,
                             exp_word.in_bounds, exp_word.was_written,
                             $sformatf("got pixel %06h pal %0d inb %0b wr %0b",
                                       got.pixel_value, got.palette_index,
                                       got.in_bounds, got.was_written));
            end
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [dtps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [dtps_pkg::CFG_DAT_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    dtps_pkg::t_in_word             in_word   = '0;
    logic                           out_ready = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    dtps_pkg::t_out_word            out_word;

    pixel_store_scoreboard          sb = new();
    int                             send_idle_pct = 14;
    int                             recv_idle_pct = 54;
    int                             items_sent    = 0;
    int                             cycle_count   = 0;
    logic [dtps_pkg::ZIN_W-1:0]     last_depth    = '0;

    depth_tested_pixel_store dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    always #1 clk = ~clk;

    // Stall the result side at random
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every delivered word
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_word(out_word);
    end

    // Abort a hung run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic dtps_pkg::t_in_word make_item(logic [dtps_pkg::MODE_W-1:0] mode,
                                                     int col, int row,
                                                     logic [dtps_pkg::COLOUR_W-1:0] colour,
                                                     logic [dtps_pkg::ZIN_W-1:0] depth);
        dtps_pkg::t_in_word word;
        word.mode        = mode;
        word.column      = dtps_pkg::COL_W'(col);
        word.row         = dtps_pkg::ROW_W'(row);
        word.colour_word = colour;
        word.depth_value = depth;
        return word;
    endfunction

    // Offer one word after a random gap and hold it until taken; called at a falling edge
    task automatic send_item(dtps_pkg::t_in_word word);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= word;
        do @(posedge clk); while (!in_ready);
        sb.note_word(word);
        if (word.mode <= dtps_pkg::MODE_CLEAR) items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write width then height; the block must be idle
    task automatic set_frame(logic [dtps_pkg::CFG_DAT_W-1:0] w_data,
                             logic [dtps_pkg::CFG_DAT_W-1:0] h_data);
        cfg_we    <= 1'b1;
        cfg_index <= dtps_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= w_data;
        @(negedge clk);
        cfg_index <= dtps_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= h_data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(dtps_pkg::CFG_FRAME_WIDTH, w_data);
        sb.set_reg(dtps_pkg::CFG_FRAME_HEIGHT, h_data);
        @(negedge clk);
    endtask

    // Build and send one random word, mostly in bounds, with depths that collide often
    task automatic random_item(int unsigned w_eff, int unsigned h_eff, bit sweeps_ok);
        logic [dtps_pkg::MODE_W-1:0]   mode;
        logic [dtps_pkg::ZIN_W-1:0]    depth;
        logic [dtps_pkg::COLOUR_W-1:0] colour;
        int                            col;
        int                            row;
        int unsigned                   pick;
        pick = $urandom_range(99);
        if (pick < 30)                   mode = dtps_pkg::MODE_PLOT;
        else if (pick < 60)              mode = dtps_pkg::MODE_DPLOT;
        else if (pick < 93)              mode = dtps_pkg::MODE_READ;
        else if (pick < 95 && sweeps_ok) mode = dtps_pkg::MODE_FILL;
        else if (pick < 97 && sweeps_ok) mode = dtps_pkg::MODE_CLEAR;
        else if (pick < 97)              mode = dtps_pkg::MODE_READ;
        else mode = MODE_SPARE + dtps_pkg::MODE_W'($urandom_range(2));
        if (w_eff > 0 && $urandom_range(9) < 8) col = $urandom_range(w_eff - 1);
        else                                   col = $urandom_range(255);
        if (h_eff > 0 && $urandom_range(9) < 8) row = $urandom_range(h_eff - 1);
        else                                   row = $urandom_range(127);
        colour = dtps_pkg::COLOUR_W'($urandom);
        case ($urandom_range(9))
            0, 1, 2, 3: depth = $urandom;
            4, 5, 6:    depth = dtps_pkg::ZIN_W'($urandom_range(2000) - 1000);
            7, 8:       depth = last_depth;
            default: begin
                case ($urandom_range(2))
                    0:       depth = DEPTH_MIN;
                    1:       depth = DEPTH_MAX;
                    default: depth = '0;
                endcase
            end
        endcase
        if (mode == dtps_pkg::MODE_DPLOT) last_depth = depth;
        send_item(make_item(mode, col, row, colour, depth));
    endtask

    initial begin
        int unsigned w;
        int unsigned h;
        int unsigned w_eff;
        int unsigned h_eff;
        int          seg_len;
        int          k;
        bit          sweeps_ok;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Define every entry of both memories at the full reset frame
        send_item(make_item(dtps_pkg::MODE_FILL, 0, 0, 24'h123456, '0));
        send_item(make_item(dtps_pkg::MODE_CLEAR, 0, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 0, 0, '0, '0));
        // Far corner with an all-ones color
        send_item(make_item(dtps_pkg::MODE_PLOT, 255, 127, 24'hFFFFFF, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 255, 127, '0, '0));
        // Depth test: equal wins, lower loses, extremes
        send_item(make_item(dtps_pkg::MODE_DPLOT, 10, 5, 24'h2E2E2E, '0));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 10, 5, 24'h111111, 32'hFFFF_FFFF));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 10, 5, 24'hD6D6D6, DEPTH_MAX));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 10, 5, 24'h222222, DEPTH_MIN));
        send_item(make_item(dtps_pkg::MODE_READ, 10, 5, '0, '0));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 11, 5, 24'h333333, DEPTH_MIN));
        send_item(make_item(dtps_pkg::MODE_READ, 11, 5, '0, '0));
        // Palette level edges around the floor and the first step
        send_item(make_item(dtps_pkg::MODE_PLOT, 3, 0, 24'h030303, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 3, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_PLOT, 4, 0, 24'h2D2E04, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 4, 0, '0, '0));
        // Spare mode codes
        send_item(make_item(MODE_SPARE, 1, 1, 24'hFFFFFF, DEPTH_MAX));
        send_item(make_item(MODE_SPARE + 3'd2, 0, 0, '0, '0));
        drain();

        // Smallest frame
        set_frame(9'd1, 9'd1);
        send_item(make_item(dtps_pkg::MODE_READ, 0, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 1, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_PLOT, 0, 1, 24'h00FF00, '0));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 0, 0, 24'hFF0000, DEPTH_MAX));
        drain();

        // Empty frame: nothing in bounds, sweeps do nothing
        set_frame(9'd0, 9'd0);
        send_item(make_item(dtps_pkg::MODE_FILL, 0, 0, 24'hABCDEF, '0));
        send_item(make_item(dtps_pkg::MODE_READ, 0, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_CLEAR, 0, 0, '0, '0));
        drain();

        // Oversized registers saturate to the full frame
        set_frame(9'h1FF, 9'h1FF);
        send_item(make_item(dtps_pkg::MODE_READ, 255, 127, '0, '0));
        send_item(make_item(dtps_pkg::MODE_CLEAR, 0, 0, '0, '0));
        send_item(make_item(dtps_pkg::MODE_DPLOT, 255, 127, 24'h0000FF, DEPTH_MIN));
        send_item(make_item(dtps_pkg::MODE_READ, 0, 0, '0, '0));
        drain();

        // Random segments, each under a new frame size
        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
                send_idle_pct = 14;
                recv_idle_pct = 54;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
                send_idle_pct = 54;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case ($urandom_range(9))
                0: begin
                    w = $urandom_range(511, 256);
                    h = $urandom_range(8, 1);
                end
                1: begin
                    w = $urandom_range(8, 1);
                    h = $urandom_range(255, 64);
                end
                2: begin
                    w = $urandom_range(511, 200);
                    h = $urandom_range(255, 100);
                end
                3: begin
                    w = $urandom_range(1) ? 0 : $urandom_range(40, 1);
                    h = (w == 0) ? $urandom_range(24) : 0;
                end
                default: begin
                    w = $urandom_range(40, 1);
                    h = $urandom_range(24, 1);
                end
            endcase
            w_eff     = (w > dtps_pkg::DEF_MAX_WIDTH) ? dtps_pkg::DEF_MAX_WIDTH : w;
            h_eff     = (h > dtps_pkg::DEF_MAX_HEIGHT) ? dtps_pkg::DEF_MAX_HEIGHT : h;
            sweeps_ok = (w_eff * h_eff <= SWEEP_AREA);
            set_frame(dtps_pkg::CFG_DAT_W'(w),
                      {1'($urandom_range(1)), dtps_pkg::HEIGHT_W'(h)});
            seg_len = $urandom_range(80, 30);
            for (k = 0; k < seg_len; k++) random_item(w_eff, h_eff, sweeps_ok);
            drain();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire

### depth_tested_pixel_store.f
rtl/dtps_pkg.sv
rtl/dtps_store.sv
rtl/dtps_core.sv
rtl/depth_tested_pixel_store.sv
rtl/dtps_checker.sv
sim/tb_depth_tested_pixel_store.sv
